>>> rtl/core/mep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_pkg: shared definitions for the Mandelbrot escape-time pixel core
// Widths, fixed-point constants, register indexes, sequencer states, saturation.
// ----------------------------------------------------------------------------
package mep_pkg;

	localparam int FRAC_BITS = 28;
	localparam int MAX_SIDE  = 4096;

	localparam int DATA_W    = 32;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int STEP_W    = 29;
	localparam int IDX_W     = $clog2(MAX_SIDE);
	localparam int CNT_W     = 16;
	localparam int COLOUR_W  = 8;
	localparam int CFG_IDX_W = 3;

	// |z|^2 escape bound, 4.0 at 2*FRAC_BITS fraction bits
	localparam logic [PROD_W-1:0] ESC_LIMIT = PROD_W'(4) << (2 * FRAC_BITS);

	localparam logic [COLOUR_W-1:0] COLOUR_INSIDE  = '0;
	localparam logic [COLOUR_W-1:0] COLOUR_ESCAPED = '1;

	localparam logic [CFG_IDX_W-1:0] CFG_REAL_ORIGIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAG_ORIGIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REAL_STEP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAG_STEP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER    = 3'd4;

	localparam logic signed [DATA_W-1:0] RST_REAL_ORIGIN = -32'sd536870912;
	localparam logic signed [DATA_W-1:0] RST_IMAG_ORIGIN = -32'sd300647711;
	localparam logic [STEP_W-1:0]        RST_REAL_STEP   = 29'd647496;
	localparam logic [STEP_W-1:0]        RST_IMAG_STEP   = 29'd587203;
	localparam logic [CNT_W-1:0]         RST_MAX_ITER    = 16'd255;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CX,
		ST_CY,
		ST_CY_ADD,
		ST_SQ_X,
		ST_SQ_Y,
		ST_XY,
		ST_UPD,
		ST_DONE
	} state_t;

	// clamp a wide signed value to the 32-bit signed range
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		logic signed [DATA_W-1:0] r;
		hi = PROD_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
		lo = -(64'sd1 <<< (DATA_W - 1));
		if (v > hi)
			r = {1'b0, {(DATA_W-1){1'b1}}};
		else if (v < lo)
			r = {1'b1, {(DATA_W-1){1'b0}}};
		else
			r = v[DATA_W-1:0];
		return r;
	endfunction

endpackage

>>> rtl/core/mandelbrot_escape_pixel_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_core: escape-time evaluator for one pixel
// Maps (column, row) to c, iterates z = z*z + c, reports count and colour.
// ----------------------------------------------------------------------------
// Flow: the core takes one pixel at a time; in_stall stays high until the
//   sequencer is back in IDLE, after the result has been registered.
// Multiplier: the single shared multiplier runs three products (x*x, y*y,
//   x*y) per iteration.
// Reset: arst_n clears the sequencer and result valid and loads the default
//   view (origin -2.0 / -1.12, 1024-pixel steps, limit 255).
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// pixel input channel
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [mep_pkg::IDX_W-1:0]              column,
	input  logic [mep_pkg::IDX_W-1:0]              row,
	// result channel
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [mep_pkg::CNT_W-1:0]              iterations,
	output logic                                   inside_res,
	output logic [mep_pkg::COLOUR_W-1:0]           colour,
	// register write channel
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [mep_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [mep_pkg::DATA_W-1:0]             cfg_data
);

	localparam int DW = mep_pkg::DATA_W;
	localparam int PW = mep_pkg::PROD_W;

	// ------------------------------------------------------------------
	// Configuration registers. Writes are always taken; indexes past the
	// list fall through and are dropped.
	// ------------------------------------------------------------------
	logic signed [DW-1:0]               real_origin_q;
	logic signed [DW-1:0]               imag_origin_q;
	logic [mep_pkg::STEP_W-1:0]         real_step_q;
	logic [mep_pkg::STEP_W-1:0]         imag_step_q;
	logic [mep_pkg::CNT_W-1:0]          max_iter_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_origin_q <= mep_pkg::RST_REAL_ORIGIN;
			imag_origin_q <= mep_pkg::RST_IMAG_ORIGIN;
			real_step_q   <= mep_pkg::RST_REAL_STEP;
			imag_step_q   <= mep_pkg::RST_IMAG_STEP;
			max_iter_q    <= mep_pkg::RST_MAX_ITER;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mep_pkg::CFG_REAL_ORIGIN: real_origin_q <= cfg_data;
				mep_pkg::CFG_IMAG_ORIGIN: imag_origin_q <= cfg_data;
				mep_pkg::CFG_REAL_STEP:   real_step_q   <= cfg_data[mep_pkg::STEP_W-1:0];
				mep_pkg::CFG_IMAG_STEP:   imag_step_q   <= cfg_data[mep_pkg::STEP_W-1:0];
				mep_pkg::CFG_MAX_ITER:    max_iter_q    <= cfg_data[mep_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sequencer. One iteration walks SQ_X -> SQ_Y -> XY -> UPD; the limit
	// is tested on entry to SQ_X, escape once both squares are in.
	// ------------------------------------------------------------------
	mep_pkg::state_t state_q, state_d;

	logic [mep_pkg::IDX_W-1:0]   col_q, row_q;
	logic signed [DW-1:0]        cx_q, cy_q;
	logic signed [DW-1:0]        x_q, y_q;
	logic [mep_pkg::CNT_W-1:0]   count_q;
	logic signed [PW-1:0]        xx_q;
	logic signed [PW-1:0]        diff_q;

	logic [mep_pkg::CNT_W-1:0]   iter_q;
	logic                        inside_q;
	logic [mep_pkg::COLOUR_W-1:0] colour_q;
	logic                        out_valid_q;

	// shared multiplier
	logic signed [DW-1:0]        mul_a, mul_b;
	logic signed [PW-1:0]        prod_q;

	mep_mult u_mult (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// |z|^2: both squares are non-negative, so the sum fits unsigned 64 bits
	logic [PW-1:0]  mag2;
	logic           escaped;
	logic           at_limit;
	logic           out_free;

	assign mag2     = PW'(xx_q) + PW'(prod_q);
	assign escaped  = (mag2 >= mep_pkg::ESC_LIMIT);
	assign at_limit = (count_q >= max_iter_q);
	assign out_free = !out_valid_q || !out_stall;

	assign in_stall = (state_q != mep_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mep_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		mul_a   = x_q;
		mul_b   = x_q;
		unique case (state_q)
			mep_pkg::ST_IDLE: begin
				if (in_valid)
					state_d = mep_pkg::ST_CX;
			end
			mep_pkg::ST_CX: begin
				mul_a   = $signed({{(DW-mep_pkg::IDX_W){1'b0}}, col_q});
				mul_b   = $signed({{(DW-mep_pkg::STEP_W){1'b0}}, real_step_q});
				state_d = mep_pkg::ST_CY;
			end
			mep_pkg::ST_CY: begin
				mul_a   = $signed({{(DW-mep_pkg::IDX_W){1'b0}}, row_q});
				mul_b   = $signed({{(DW-mep_pkg::STEP_W){1'b0}}, imag_step_q});
				state_d = mep_pkg::ST_CY_ADD;
			end
			mep_pkg::ST_CY_ADD: begin
				state_d = mep_pkg::ST_SQ_X;
			end
			mep_pkg::ST_SQ_X: begin
				mul_a   = x_q;
				mul_b   = x_q;
				state_d = at_limit ? mep_pkg::ST_DONE : mep_pkg::ST_SQ_Y;
			end
			mep_pkg::ST_SQ_Y: begin
				mul_a   = y_q;
				mul_b   = y_q;
				state_d = mep_pkg::ST_XY;
			end
			mep_pkg::ST_XY: begin
				mul_a   = x_q;
				mul_b   = y_q;
				state_d = escaped ? mep_pkg::ST_DONE : mep_pkg::ST_UPD;
			end
			mep_pkg::ST_UPD: begin
				state_d = mep_pkg::ST_SQ_X;
			end
			mep_pkg::ST_DONE: begin
				if (out_free)
					state_d = mep_pkg::ST_IDLE;
			end
			default: state_d = mep_pkg::ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Datapath. Shifts are arithmetic, i.e. floor; z saturates per step.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			mep_pkg::ST_IDLE: begin
				if (in_valid) begin
					col_q <= column;
					row_q <= row;
				end
			end
			mep_pkg::ST_CY: begin
				cx_q <= mep_pkg::sat32(PW'(real_origin_q) + prod_q);
			end
			mep_pkg::ST_CY_ADD: begin
				cy_q    <= mep_pkg::sat32(PW'(imag_origin_q) + prod_q);
				x_q     <= '0;
				y_q     <= '0;
				count_q <= '0;
			end
			mep_pkg::ST_SQ_Y: begin
				xx_q <= prod_q;
			end
			mep_pkg::ST_XY: begin
				diff_q <= xx_q - prod_q;
			end
			mep_pkg::ST_UPD: begin
				x_q     <= mep_pkg::sat32((diff_q >>> mep_pkg::FRAC_BITS) + PW'(cx_q));
				y_q     <= mep_pkg::sat32((prod_q >>> (mep_pkg::FRAC_BITS - 1)) + PW'(cy_q));
				count_q <= count_q + 1'b1;
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Result register: holds the beat until the sink takes it.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == mep_pkg::ST_DONE && out_free)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == mep_pkg::ST_DONE && out_free) begin
			iter_q   <= count_q;
			inside_q <= (count_q == max_iter_q);
			colour_q <= (count_q == max_iter_q) ? mep_pkg::COLOUR_INSIDE
			                                    : mep_pkg::COLOUR_ESCAPED;
		end
	end

	assign out_valid  = out_valid_q;
	assign iterations = iter_q;
	assign inside_res = inside_q;
	assign colour     = colour_q;

endmodule

>>> rtl/core/mep_mult.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mep_mult: shared signed multiplier
// 32 x 32 signed product, registered; result in the cycle after the operands.
// ----------------------------------------------------------------------------
module mep_mult (
	input  logic                                   clk,
	input  logic signed [mep_pkg::DATA_W-1:0]      a,
	input  logic signed [mep_pkg::DATA_W-1:0]      b,
	output logic signed [mep_pkg::PROD_W-1:0]      prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule
